### rtl/tpdls_pkg.sv
// shared types and constants for the two-pass dda line stepper
package tpdls_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COLOR_W    = 32;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT
  } state_e;

  typedef enum logic [1:0] {
    PH_X    = 2'd0,
    PH_Y    = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  typedef struct packed {
    logic load;
    logic step;
    logic slope_x_we;
    logic slope_y_we;
  } walk_ctrl_t;

endpackage

### rtl/two_pass_dda_line_stepper.sv
// top level of the two-pass dda line stepper: sequencer and result register
//
// Input channel: in_valid_i / in_stall_o with func_i and the segment fields.
// func_i = load stores a segment and forms both slopes; it returns nothing.
// func_i = step returns one transaction on the output channel: the next pixel,
// or pixel_valid_o = 0 with last_o = 1 once both passes are over.
// A step's result is registered into the output register in the cycle after
// it is taken; steps can follow back to back at one per cycle while in_stall_o is low.
// A load then stalls the input while the single shared divider forms the two
// slopes one after the other, producing one quotient bit per cycle for each
// (12.16 quotients at the default widths); the next transaction is taken once
// both slopes are written.
// Output channel: out_valid_o / out_stall_i. While a result is held under
// stall, the input stalls as well; nothing is dropped or repeated.
// Reset leaves no segment loaded: a step then returns the end marker.
module two_pass_dda_line_stepper #(
  parameter int unsigned CoordBits = tpdls_pkg::COORD_BITS,
  parameter int unsigned FracBits  = tpdls_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [CoordBits-1:0]   x_start_i,
  input  logic signed [CoordBits-1:0]   y_start_i,
  input  logic signed [CoordBits-1:0]   x_end_i,
  input  logic signed [CoordBits-1:0]   y_end_i,
  input  logic [tpdls_pkg::COLOR_W-1:0] color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [CoordBits-1:0]   pixel_x_o,
  output logic signed [CoordBits-1:0]   pixel_y_o,
  output logic [tpdls_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                          pixel_valid_o,
  output logic                          last_o
);
  import tpdls_pkg::*;

  localparam int unsigned NumW = CoordBits + FracBits;
  localparam int unsigned DenW = CoordBits + 1;

  state_e                      state_q, state_d;
  walk_ctrl_t                  ctrl;
  logic                        accept;
  logic                        div_start;
  logic                        div_done;
  logic [NumW-1:0]             quotient;
  logic signed [CoordBits:0]   dx, dy, num, den;
  logic [CoordBits:0]          num_mag, den_mag;
  logic [NumW-1:0]             dividend;
  logic signed [CoordBits-1:0] w_px, w_py;
  logic [COLOR_W-1:0]          w_color;
  logic                        w_valid, w_last;
  logic                        out_valid_q, out_valid_d;
  logic signed [CoordBits-1:0] pixel_x_q, pixel_y_q;
  logic [COLOR_W-1:0]          pixel_color_q;
  logic                        pixel_valid_q, last_q;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d         = state_q;
    div_start       = 1'b0;
    ctrl.load       = 1'b0;
    ctrl.step       = 1'b0;
    ctrl.slope_x_we = 1'b0;
    ctrl.slope_y_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_LOAD) begin
            ctrl.load = 1'b1;
            state_d   = ST_X_GO;
          end else begin
            ctrl.step = 1'b1;
          end
        end
      end
      ST_X_GO: begin
        div_start = 1'b1;
        state_d   = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (div_done) begin
          ctrl.slope_x_we = 1'b1;
          state_d         = ST_Y_GO;
        end
      end
      ST_Y_GO: begin
        div_start = 1'b1;
        state_d   = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_done) begin
          ctrl.slope_y_we = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // slope along x uses dy / dx, slope along y uses dx / dy
  assign num      = (state_q == ST_Y_GO) ? dx : dy;
  assign den      = (state_q == ST_Y_GO) ? dy : dx;
  assign num_mag  = num[CoordBits] ? 
                    (CoordBits + 1)'(-num) : (CoordBits + 1)'(num);
  assign den_mag  = den[CoordBits] ? 
                    (CoordBits + 1)'(-den) : (CoordBits + 1)'(den);
  assign dividend = {num_mag[CoordBits-1:0], {FracBits{1'b0}}};

  tpdls_div #(
    .NumW(NumW),
    .DenW(DenW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (den_mag),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  tpdls_walker #(
    .CoordBits(CoordBits),
    .FracBits (FracBits)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .color_i      (color_i),
    .quotient_i   (quotient),
    .dx_o         (dx),
    .dy_o         (dy),
    .pixel_x_o    (w_px),
    .pixel_y_o    (w_py),
    .pixel_color_o(w_color),
    .pixel_valid_o(w_valid),
    .last_o       (w_last)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.step) begin
      pixel_x_q     <= w_px;
      pixel_y_q     <= w_py;
      pixel_color_q <= w_color;
      pixel_valid_q <= w_valid;
      last_q        <= w_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = pixel_color_q;
  assign pixel_valid_o = pixel_valid_q;
  assign last_o        = last_q;

endmodule

### rtl/tpdls_div.sv
// shared restoring divider, one quotient bit per cycle
module tpdls_div #(
  parameter int unsigned NumW = 28,
  parameter int unsigned DenW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quotient_o
);
  import tpdls_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/tpdls_walker.sv
// segment state, slopes and the per-step position update
module tpdls_walker #(
  parameter int unsigned CoordBits = tpdls_pkg::COORD_BITS,
  parameter int unsigned FracBits  = tpdls_pkg::FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tpdls_pkg::walk_ctrl_t             ctrl_i,
  input  logic signed [CoordBits-1:0]       x_start_i,
  input  logic signed [CoordBits-1:0]       y_start_i,
  input  logic signed [CoordBits-1:0]       x_end_i,
  input  logic signed [CoordBits-1:0]       y_end_i,
  input  logic [tpdls_pkg::COLOR_W-1:0]     color_i,
  input  logic [CoordBits+FracBits-1:0]     quotient_i,
  output logic signed [CoordBits:0]         dx_o,
  output logic signed [CoordBits:0]         dy_o,
  output logic signed [CoordBits-1:0]       pixel_x_o,
  output logic signed [CoordBits-1:0]       pixel_y_o,
  output logic [tpdls_pkg::COLOR_W-1:0]     pixel_color_o,
  output logic                              pixel_valid_o,
  output logic                              last_o
);
  import tpdls_pkg::*;

  localparam int unsigned PosBits   = CoordBits + FracBits;
  localparam int unsigned SlopeBits = PosBits + 1;
  localparam logic [PosBits-1:0] Unit = PosBits'(1) << FracBits;

  phase_e                      phase_q, phase_d, step_phase;
  logic signed [PosBits-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [PosBits-1:0]   step_x, step_y;
  logic signed [PosBits-1:0]   x_nx, y_nx;
  logic signed [SlopeBits-1:0] slope_x_q, slope_y_q, slope_mag, slope_x_d, slope_y_d;
  logic signed [CoordBits-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [COLOR_W-1:0]          color_q;
  logic signed [PosBits-1:0]   start_x_fx, start_y_fx, end_x_fx, end_y_fx;
  logic [CoordBits-1:0]        px, py;
  logic                        running;

  function automatic logic [CoordBits-1:0] trunc_pos(input logic [PosBits-1:0] p);
    logic [CoordBits-1:0] fl;
    logic                 up;
    fl = p[PosBits-1:FracBits];
    up = p[PosBits-1] & (|p[FracBits-1:0]);
    return fl + {{(CoordBits-1){1'b0}}, up};
  endfunction

  assign start_x_fx = $signed({start_x_q, {FracBits{1'b0}}});
  assign start_y_fx = $signed({start_y_q, {FracBits{1'b0}}});
  assign end_x_fx   = $signed({end_x_q, {FracBits{1'b0}}});
  assign end_y_fx   = $signed({end_y_q, {FracBits{1'b0}}});

  assign dx_o = $signed({end_x_q[CoordBits-1], end_x_q})
              - $signed({start_x_q[CoordBits-1], start_x_q});
  assign dy_o = $signed({end_y_q[CoordBits-1], end_y_q})
              - $signed({start_y_q[CoordBits-1], start_y_q});

  assign px = trunc_pos(pos_x_q);
  assign py = trunc_pos(pos_y_q);

  // next state of one pixel step
  always_comb begin
    step_phase = phase_q;
    step_x     = pos_x_q;
    step_y     = pos_y_q;
    x_nx       = '0;
    y_nx       = '0;
    running    = 1'b0;
    unique case (phase_q)
      PH_X: begin
        running = 1'b1;
        x_nx    = $signed(pos_x_q + Unit);
        y_nx    = $signed(pos_y_q + slope_x_q[PosBits-1:0]);
        if (x_nx < end_x_fx) begin
          step_x = x_nx;
          step_y = y_nx;
        end else begin
          step_x     = start_x_fx;
          step_y     = start_y_fx;
          step_phase = (end_y_q > start_y_q) ? PH_Y : PH_DONE;
        end
      end
      PH_Y: begin
        running = 1'b1;
        y_nx    = $signed(pos_y_q + Unit);
        x_nx    = $signed(pos_x_q + slope_y_q[PosBits-1:0]);
        step_x  = x_nx;
        step_y  = y_nx;
        if (!(y_nx < end_y_fx)) begin
          step_phase = PH_DONE;
        end
      end
      default: begin
        step_phase = phase_q;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (ctrl_i.load) begin
      pos_x_d = $signed({x_start_i, {FracBits{1'b0}}});
      pos_y_d = $signed({y_start_i, {FracBits{1'b0}}});
      if (x_end_i > x_start_i) begin
        phase_d = PH_X;
      end else if (y_end_i > y_start_i) begin
        phase_d = PH_Y;
      end else begin
        phase_d = PH_DONE;
      end
    end else if (ctrl_i.step) begin
      phase_d = step_phase;
      pos_x_d = step_x;
      pos_y_d = step_y;
    end
  end

  // sign and zero-divisor handling of the divider result
  assign slope_mag = $signed({1'b0, quotient_i});
  assign slope_x_d = (dx_o == '0) ? '0 : ((dy_o[CoordBits] ^ dx_o[CoordBits]) ?
                     -slope_mag : slope_mag);
  assign slope_y_d = (dy_o == '0) ? '0 : ((dx_o[CoordBits] ^ dy_o[CoordBits]) ?
                     -slope_mag : slope_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
    if (ctrl_i.load) begin
      start_x_q <= x_start_i;
      start_y_q <= y_start_i;
      end_x_q   <= x_end_i;
      end_y_q   <= y_end_i;
      color_q   <= color_i;
    end
    if (ctrl_i.slope_x_we) begin
      slope_x_q <= slope_x_d;
    end
    if (ctrl_i.slope_y_we) begin
      slope_y_q <= slope_y_d;
    end
  end

  assign pixel_valid_o = running;
  assign pixel_x_o     = running ? $signed(px) : '0;
  assign pixel_y_o     = running ? $signed(py) : '0;
  assign pixel_color_o = running ? color_q : '0;
  assign last_o        = !running || (step_phase == PH_DONE);

endmodule

### verif/two_pass_dda_line_stepper_test.sv
// self-checking testbench for the two-pass dda line stepper
module two_pass_dda_line_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tpdls_pkg::*;

  localparam int unsigned POS_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned ITEMS      = 1750;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN      = 80;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_W-1:0]      fix_t;
  typedef logic signed [POS_W:0]        slope_t;

  typedef struct {
    coord_t             x;
    coord_t             y;
    logic [COLOR_W-1:0] color;
    logic               valid;
    logic               last;
  } pixel_t;

  class pixel_scoreboard;
    phase_e             phase;
    fix_t               pos_x, pos_y;
    slope_t             slope_x_maj, slope_y_maj;
    coord_t             sx, sy, ex, ey;
    logic [COLOR_W-1:0] seg_color;
    pixel_t             pending_pixels[$];
    int unsigned        errors, loads, steps, pixels, markers;

    function new();
      phase       = PH_DONE;
      pos_x       = '0;
      pos_y       = '0;
      slope_x_maj = '0;
      slope_y_maj = '0;
      sx          = '0;
      sy          = '0;
      ex          = '0;
      ey          = '0;
      seg_color   = '0;
    endfunction

    function fix_t fixed_of(coord_t c);
      return {c, {FRAC_BITS{1'b0}}};
    endfunction

    // truncation toward zero
    function coord_t whole_part(fix_t p);
      longint v;
      v = p;
      if (v < 0) v = -((-v) >> FRAC_BITS);
      else v = v >> FRAC_BITS;
      return v[COORD_BITS-1:0];
    endfunction

    function slope_t slope_of(int num, int den);
      longint q;
      if (den == 0) return '0;
      q = (longint'(num < 0 ? -num : num) << FRAC_BITS) / longint'(den < 0 ? -den : den);
      if ((num < 0) != (den < 0)) q = -q;
      return q[POS_W:0];
    endfunction

    function void restart_y();
      pos_x = fixed_of(sx);
      pos_y = fixed_of(sy);
      phase = (ey > sy) ? PH_Y : PH_DONE;
    endfunction

    function void note_input(logic fn, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                             logic [COLOR_W-1:0] col);
      pixel_t px;
      if (fn == FUNC_LOAD) begin
        loads++;
        sx          = xs;
        sy          = ys;
        ex          = xe;
        ey          = ye;
        seg_color   = col;
        slope_x_maj = slope_of(int'(ye) - int'(ys), int'(xe) - int'(xs));
        slope_y_maj = slope_of(int'(xe) - int'(xs), int'(ye) - int'(ys));
        pos_x       = fixed_of(xs);
        pos_y       = fixed_of(ys);
        if (xe > xs) phase = PH_X;
        else restart_y();
        return;
      end
      steps++;
      if (phase != PH_X && phase != PH_Y) begin
        px.x     = '0;
        px.y     = '0;
        px.color = '0;
        px.valid = 1'b0;
        px.last  = 1'b1;
        pending_pixels.push_back(px);
        return;
      end
      px.x     = whole_part(pos_x);
      px.y     = whole_part(pos_y);
      px.color = seg_color;
      px.valid = 1'b1;
      if (phase == PH_X) begin
        pos_x = pos_x + fixed_of(coord_t'(1));
        pos_y = pos_y + slope_x_maj[POS_W-1:0];
        if (!(pos_x < fixed_of(ex))) restart_y();
      end else begin
        pos_y = pos_y + fixed_of(coord_t'(1));
        pos_x = pos_x + slope_y_maj[POS_W-1:0];
        if (!(pos_y < fixed_of(ey))) phase = PH_DONE;
      end
      px.last = (phase == PH_DONE);
      pending_pixels.push_back(px);
    endfunction

    function void check_field(string name, logic [COLOR_W-1:0] e, logic [COLOR_W-1:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output transaction x=%0h y=%0h", $time, got.x, got.y);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (want.valid) pixels++;
      else markers++;
      check_field("pixel_x", want.x, got.x);
      check_field("pixel_y", want.y, got.y);
      check_field("pixel_color", want.color, got.color);
      check_field("pixel_valid", want.valid, got.valid);
      check_field("last", want.last, got.last);
    endfunction

    function void close_out();
      if (pending_pixels.size() != 0) begin
        $display("%0t: %0d expected transactions never arrived", $time, pending_pixels.size());
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  coord_t             x_start_i, y_start_i, x_end_i, y_end_i;
  logic [COLOR_W-1:0] color_i;
  logic               out_valid_o;
  logic               out_stall_i;
  coord_t             pixel_x_o, pixel_y_o;
  logic [COLOR_W-1:0] pixel_color_o;
  logic               pixel_valid_o;
  logic               last_o;

  pixel_scoreboard sb;
  int unsigned     max_gap;
  int unsigned     items_sent;
  int unsigned     idle_cycles;

  two_pass_dda_line_stepper uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .x_start_i,
    .y_start_i,
    .x_end_i,
    .y_end_i,
    .color_i,
    .out_valid_o,
    .out_stall_i,
    .pixel_x_o,
    .pixel_y_o,
    .pixel_color_o,
    .pixel_valid_o,
    .last_o
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic drive_item(input logic fn, input coord_t xs, input coord_t ys,
                            input coord_t xe, input coord_t ye, input logic [COLOR_W-1:0] col);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    x_start_i  <= xs;
    y_start_i  <= ys;
    x_end_i    <= xe;
    y_end_i    <= ye;
    color_i    <= col;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_load(input coord_t xs, input coord_t ys, input coord_t xe, input coord_t ye,
                           input logic [COLOR_W-1:0] col);
    drive_item(FUNC_LOAD, xs, ys, xe, ye, col);
  endtask

  // fields of a step are ignored, so they carry noise
  task automatic send_step();
    drive_item(FUNC_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), $urandom);
  endtask

  // start and end of one axis, end - start within [lo_d, hi_d], one of them often at a range edge
  task automatic pick_span(output coord_t a, output coord_t b, input int lo_d, input int hi_d);
    int d, lowest, highest, base, e;
    d       = int'($urandom_range(0, hi_d - lo_d)) + lo_d;
    lowest  = -2048 - (d < 0 ? d : 0);
    highest = 2047 - (d > 0 ? d : 0);
    case ($urandom_range(0, 9))
      0: base = lowest;
      1: base = highest;
      default: base = lowest + int'($urandom_range(0, highest - lowest));
    endcase
    e = base + d;
    a = base[COORD_BITS-1:0];
    b = e[COORD_BITS-1:0];
  endtask

  initial begin
    int unsigned n, walk, sel, last_switch;
    coord_t      xs, ys, xe, ye;
    in_valid_i  = 1'b0;
    func_i      = FUNC_LOAD;
    x_start_i   = '0;
    y_start_i   = '0;
    x_end_i     = '0;
    y_end_i     = '0;
    color_i     = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;
    max_gap     = 5;
    items_sent  = 0;
    last_switch = 0;
    sb          = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_step();
    send_load(0, 0, 0, 0, 32'h0000_0000);
    send_step();
    send_load(0, 0, 3, 0, 32'hffff_ffff);
    repeat (4) send_step();
    send_load(5, -2, 5, 1, 32'h5a5a_a5a5);
    repeat (4) send_step();
    send_load(3, 3, -2, -4, 32'h1234_5678);
    send_step();
    send_load(-2048, -2048, 2047, 2047, 32'h8000_0001);
    repeat (2) send_step();
    send_load(-3, -1, -1, 2, 32'hdead_beef);
    repeat (6) send_step();

    while (items_sent < ITEMS) begin
      if (items_sent - last_switch >= 150) begin
        last_switch = items_sent;
        max_gap     = ($urandom_range(0, 3) == 0) ? 0 : 5;
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        xs = coord_t'($urandom);
        ys = coord_t'($urandom);
        xe = coord_t'($urandom);
        ye = coord_t'($urandom);
        send_load(xs, ys, xe, ye, $urandom);
        n = $urandom_range(0, 24);
      end else if (sel == 1) begin
        n = $urandom_range(1, 3);
      end else begin
        pick_span(xs, xe, -6, 14);
        pick_span(ys, ye, -6, 14);
        send_load(xs, ys, xe, ye, $urandom);
        walk = (xe > xs ? int'(xe) - int'(xs) : 0) + (ye > ys ? int'(ye) - int'(ys) : 0);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, walk);
        else n = walk + $urandom_range(0, 2);
      end
      repeat (n) send_step();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    sb.close_out();
    $display("covered %0d segment loads and %0d steps", sb.loads, sb.steps);
    $display("checked %0d pixels and %0d end markers, %0d errors",
             sb.pixels, sb.markers, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS two_pass_dda_line_stepper");
    end else begin
      $display("FAIL two_pass_dda_line_stepper");
    end
    $finish;
  end

  // output back-pressure
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(0, max_gap);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    pixel_t got;
    logic   moved;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        got.x     = pixel_x_o;
        got.y     = pixel_y_o;
        got.color = pixel_color_o;
        got.valid = pixel_valid_o;
        got.last  = last_o;
        sb.check_result(got);
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(func_i, x_start_i, y_start_i, x_end_i, y_end_i, color_i);
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL two_pass_dda_line_stepper");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
